### sv/utf8_key_entry_buffer_defines.svh
// Assertion macros for the key entry buffer checks.
`ifndef UTF8_KEY_ENTRY_BUFFER_DEFINES_SVH
`define UTF8_KEY_ENTRY_BUFFER_DEFINES_SVH

// Same-cycle implication, gated off while reset is asserted
`define UKEB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off while reset is asserted
`define UKEB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ukeb_pkg.sv
package ukeb_pkg;

  // Buffer geometry
  localparam int BUF_BYTES = 8192;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int CNT_W     = ADDR_W + 1;

  localparam int KEY_W = 21;

  // Special key codes
  localparam logic [KEY_W-1:0] KEY_BACK = 21'h00_0008;
  localparam logic [KEY_W-1:0] KEY_SAVE = 21'h00_0013;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_NAV_LOW  = 1'b0,
    CFG_NAV_HIGH = 1'b1
  } ukeb_cfg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_WRITE,
    ST_BACK_RD,
    ST_BACK_CHK,
    ST_DONE
  } ukeb_state_e;

  typedef logic [ADDR_W-1:0] ukeb_addr_t;
  typedef logic [CNT_W-1:0]  ukeb_cnt_t;

  // Request from the sequencer to the byte store
  typedef struct packed {
    logic       we;
    ukeb_addr_t waddr;
    logic [7:0] wdata;
    logic       re;
    ukeb_addr_t raddr;
  } ukeb_mem_req_t;

  // Encoded character: lead byte in the top lane, then continuation bytes
  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  len;
  } ukeb_enc_t;

  function automatic ukeb_enc_t ukeb_encode(input logic [KEY_W-1:0] cp);
    ukeb_enc_t e;
    if (cp < 21'h00_0080) begin
      e.bytes = {cp[7:0], 24'h00_0000};
      e.len   = 3'd1;
    end else if (cp < 21'h00_0800) begin
      e.bytes = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0000};
      e.len   = 3'd2;
    end else if (cp < 21'h01_0000) begin
      e.bytes = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h00};
      e.len   = 3'd3;
    end else begin
      e.bytes = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                 2'b10, cp[5:0]};
      e.len   = 3'd4;
    end
    return e;
  endfunction

  // True for a UTF-8 continuation byte
  function automatic logic ukeb_is_cont(input logic [7:0] b);
    return (b[7:6] == 2'b10);
  endfunction

endpackage

### sv/ukeb_store.sv
module ukeb_store (
  input  logic                   clk_i,
  input  ukeb_pkg::ukeb_mem_req_t req_i,
  output logic [7:0]             rdata_o
);
  import ukeb_pkg::*;

  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rdata_q;

  // Single write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/utf8_key_entry_buffer.sv
// Key entry buffer: takes one key code per request (start_i while busy_o is low) and
// reports exactly one result, a single-cycle done_o strobe with changed, save request,
// byte count and dirty flag; the receiver cannot stall it. The result ports are only
// valid while done_o is high, since they move while a request is being worked on.
// For navigation, save, null and refused keys the request passes through ST_CLASSIFY and
// then ST_DONE, which gives the strobe, after which busy_o falls.
// An append writes its bytes (1 to 4) one at a time in ST_WRITE, since all bytes go through the
// single store write port. A backspace takes each byte examined through ST_BACK_RD and then
// ST_BACK_CHK, as the store read is registered: up to 4 bytes, 3 continuation bytes and the lead.
// The byte store holds no reset value and needs no clearing pass, so requests are taken
// from the first cycle after reset. Configuration writes are always ready and should
// only be issued while busy_o is low.
module utf8_key_entry_buffer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [ukeb_pkg::KEY_W-1:0]      key_code_i,
  output logic                            done_o,
  output logic                            changed_o,
  output logic                            save_request_o,
  output logic [ukeb_pkg::CNT_W-1:0]      text_length_o,
  output logic                            dirty_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  ukeb_pkg::ukeb_cfg_e             cfg_index_i,
  input  logic [ukeb_pkg::KEY_W-1:0]      cfg_wdata_i
);
  import ukeb_pkg::*;

  ukeb_state_e      state_q, state_d;
  ukeb_cnt_t        count_q, count_d;
  logic             saved_q, saved_d;
  logic             chg_q, chg_d;
  logic             save_q, save_d;
  logic [KEY_W-1:0] nav_low_q, nav_high_q;

  logic [KEY_W-1:0] key_q, key_d;
  logic [31:0]      enc_q, enc_d;
  logic [2:0]       nleft_q, nleft_d;
  ukeb_addr_t       p_q, p_d;

  ukeb_mem_req_t    mem_req;
  logic [7:0]       mem_rdata;
  ukeb_enc_t        enc;
  ukeb_cnt_t        cnt_m1;
  logic [CNT_W:0]   cnt_sum;
  logic             is_nav;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nav_low_q  <= 21'h11_0000;
      nav_high_q <= 21'h11_0007;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NAV_LOW:  nav_low_q  <= cfg_wdata_i;
        CFG_NAV_HIGH: nav_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      saved_q <= 1'b1;
      chg_q   <= 1'b0;
      save_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      saved_q <= saved_d;
      chg_q   <= chg_d;
      save_q  <= save_d;
    end
  end

  // Working registers of the current key
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    enc_q   <= enc_d;
    nleft_q <= nleft_d;
    p_q     <= p_d;
  end

  // Key classification helpers
  assign enc     = ukeb_encode(key_q);
  assign cnt_m1  = count_q - 1'b1;
  assign cnt_sum = {1'b0, count_q} + {{(CNT_W-2){1'b0}}, enc.len};
  assign is_nav  = (key_q >= nav_low_q) && (key_q <= nav_high_q);

  // Sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    saved_d = saved_q;
    chg_d   = chg_q;
    save_d  = save_q;
    key_d   = key_q;
    enc_d   = enc_q;
    nleft_d = nleft_q;
    p_d     = p_q;
    mem_req = '0;
    done_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          key_d   = key_code_i;
          state_d = ST_CLASSIFY;
        end
      end

      ST_CLASSIFY: begin
        chg_d   = 1'b0;
        save_d  = 1'b0;
        state_d = ST_DONE;
        if (is_nav) begin
          // navigation keys are dropped
        end else if (key_q == KEY_SAVE) begin
          chg_d  = 1'b1;
          save_d = 1'b1;
        end else if (key_q == KEY_BACK) begin
          if (count_q != '0) begin
            if (cnt_m1 == '0) begin
              count_d = '0;
              saved_d = 1'b0;
              chg_d   = 1'b1;
            end else begin
              p_d     = cnt_m1[ADDR_W-1:0];
              state_d = ST_BACK_RD;
            end
          end
        end else if (key_q inside {[21'h00_0001:21'h00_007F]}) begin
          if (count_q < CNT_W'(BUF_BYTES)) begin
            enc_d   = enc.bytes;
            nleft_d = enc.len;
            state_d = ST_WRITE;
          end
        end else if (key_q != '0) begin
          // multi-byte character needs the sum strictly below capacity
          if (cnt_sum < (CNT_W+1)'(BUF_BYTES)) begin
            enc_d   = enc.bytes;
            nleft_d = enc.len;
            state_d = ST_WRITE;
          end
        end
      end

      // one byte per cycle from the top lane
      ST_WRITE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = count_q[ADDR_W-1:0];
        mem_req.wdata = enc_q[31:24];
        enc_d         = {enc_q[23:0], 8'h00};
        nleft_d       = nleft_q - 1'b1;
        count_d       = count_q + 1'b1;
        if (nleft_q == 3'd1) begin
          saved_d = 1'b0;
          chg_d   = 1'b1;
          state_d = ST_DONE;
        end
      end

      ST_BACK_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = p_q;
        state_d       = ST_BACK_CHK;
      end

      // step back over continuation bytes, stopping at index one; a continuation byte there clears the text
      ST_BACK_CHK: begin
        if (ukeb_is_cont(mem_rdata) && (p_q != ADDR_W'(1))) begin
          p_d     = p_q - 1'b1;
          state_d = ST_BACK_RD;
        end else begin
          if (ukeb_is_cont(mem_rdata)) begin
            count_d = '0;
          end else begin
            count_d = {1'b0, p_q};
          end
          saved_d = 1'b0;
          chg_d   = 1'b1;
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign changed_o      = chg_q;
  assign save_request_o = save_q;
  assign text_length_o  = count_q;
  assign dirty_o        = !saved_q;

  ukeb_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

### sv/ukeb_checker.sv
`include "utf8_key_entry_buffer_defines.svh"

module ukeb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       done_o,
  input logic                       changed_o,
  input logic                       save_request_o,
  input logic [ukeb_pkg::CNT_W-1:0] text_length_o,
  input logic                       dirty_o
);
  import ukeb_pkg::*;

  // an accepted request keeps the block busy in the following cycle
  `UKEB_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o, "accepted request did not raise busy")

  // the result strobe closes the request
  `UKEB_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy_o && !done_o, "block still busy after result strobe")

  // a save request always counts as a change
  `UKEB_ASSERT_NOW(a_save_changed, clk_i, rst_ni, done_o && save_request_o, changed_o, "save request without changed")

  // byte count never exceeds capacity, and a change other than save leaves the text dirty
  `UKEB_ASSERT_NOW(a_len_dirty, clk_i, rst_ni, done_o, (text_length_o <= CNT_W'(BUF_BYTES)) && (!changed_o || save_request_o || dirty_o), "bad length or clean after edit")

endmodule

bind utf8_key_entry_buffer ukeb_checker u_ukeb_checker (.*);
